// ----- design/motor_endstop_current_detector_unit_defines.svh -----
// assertion macros for the end-stop current detector
`ifndef MOTOR_ENDSTOP_CURRENT_DETECTOR_UNIT_DEFINES_SVH
`define MOTOR_ENDSTOP_CURRENT_DETECTOR_UNIT_DEFINES_SVH

// same-cycle implication, checked on aclk outside reset
`define MECD_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked on aclk outside reset
`define MECD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- design/mecd_pkg.sv -----
`default_nettype none

package mecd_pkg;

    localparam int CfgDataWidth = 48;
    localparam int CfgIndexWidth = 3;

    localparam logic [CfgIndexWidth-1:0] CfgIntegralDecay = 3'd0;
    localparam logic [CfgIndexWidth-1:0] CfgIntegralLimit = 3'd1;
    localparam logic [CfgIndexWidth-1:0] CfgEdgeRiseThreshold = 3'd2;
    localparam logic [CfgIndexWidth-1:0] CfgMinSteepness = 3'd3;
    localparam logic [CfgIndexWidth-1:0] CfgFallingRatio = 3'd4;

    localparam logic [1:0] OpSample = 2'd0;
    localparam logic [1:0] OpReadClear = 2'd1;
    localparam logic [1:0] OpClear = 2'd2;

    localparam logic [1:0] DetNone = 2'd0;
    localparam logic [1:0] DetOvercurrent = 2'd1;
    localparam logic [1:0] DetRisingEdge = 2'd2;

    // adc to microamps, filter weight and exact reciprocal of 179 (valid below 2^31)
    localparam logic [31:0] AdcScale = 32'd806;
    localparam logic [31:0] FiltKeep = 32'd178;
    localparam logic [31:0] FiltRecip = 32'd3071261531;
    localparam int FiltShift = 39;
    localparam logic [21:0] FiltMax = 22'd3300570;

    typedef struct packed {
        logic [1:0]  op;
        logic [11:0] adc_sample;
        logic [63:0] sample_time;
    } in_word_t;

    typedef struct packed {
        logic [1:0]  detect_state;
        logic [63:0] event_time;
        logic [21:0] filtered_current;
    } out_word_t;

endpackage

`default_nettype wire

// ----- design/motor_endstop_current_detector_unit.sv -----
// Motor end-stop current detector.
// Input words (s_valid/s_ready/s_data) carry an op, a raw 12-bit ADC current
// sample and a microsecond timestamp. Op sample filters the current, updates
// the leaky current-time integral and, on every DECIMATION-th sample, runs the
// rising-edge tracker. Op read-and-clear reports and clears the latched state,
// op clear clears it. Every input word gives exactly one result word
// (m_valid/m_ready/m_data): latched state, event time and filtered current.
// Configuration registers are written through cfg_we/cfg_index/cfg_wdata; the
// user must do so only while the block is idle (the block does not enforce it).
// Writes to unknown indexes are ignored.
// One 32x32 multiplier is shared by all products under a sequencer. A sample
// word steps through the filter, integral and limit states and, on a decimated
// sample, the edge tracker, which stops once a rising edge latches; other ops
// go straight to the result state. s_ready is low while a word is in work.
// A finished result sits in the output register; the next input word is still
// taken while it waits, but that word's result holds until m_ready frees it.
// Reset (aresetn low, synchronous) clears the sequencer, filter, integral, edge
// and latch state and loads the register defaults.
`default_nettype none

module motor_endstop_current_detector_unit
    import mecd_pkg::*;
#(
    parameter int DECIMATION = 20
) (
    input  wire logic                     aclk,
    input  wire logic                     aresetn,
    input  wire logic                     s_valid,
    output logic                          s_ready,
    input  wire in_word_t                 s_data,
    output logic                          m_valid,
    input  wire logic                     m_ready,
    output out_word_t                     m_data,
    input  wire logic                     cfg_we,
    input  wire logic [CfgIndexWidth-1:0] cfg_index,
    input  wire logic [CfgDataWidth-1:0]  cfg_wdata
);

    localparam logic [7:0] DecimCount = 8'(DECIMATION);

    typedef enum logic [3:0] {
        ST_IDLE, ST_KEEP, ST_CUR, ST_SUM, ST_DIV, ST_INT, ST_DEC, ST_SUB,
        ST_LIM, ST_RISE, ST_STLO, ST_STHI, ST_STCMP, ST_FALLM, ST_FALLC, ST_DONE
    } state_t;

    state_t state_reg;

    logic [21:0] decay_reg;
    logic [47:0] limit_reg;
    logic [21:0] rise_thr_reg;
    logic [15:0] steep_min_reg;
    logic [7:0]  ratio_reg;

    in_word_t    in_reg;
    out_word_t   out_reg;
    logic        m_valid_reg;

    logic [21:0] filter_value_reg;
    logic [63:0] last_time_reg;
    logic [63:0] integ_reg;
    logic [7:0]  decim_reg;
    logic [21:0] prev_dec_reg;
    logic [21:0] edge_level_reg;
    logic [63:0] edge_time_reg;
    logic [21:0] edge_peak_reg;
    logic [1:0]  latched_state_reg;
    logic [63:0] latched_time_reg;

    logic [63:0] prod_reg;
    logic [31:0] dt_reg;
    logic [30:0] num_reg;
    logic [21:0] f_reg;
    logic [21:0] old_reg;
    logic [63:0] span_reg;
    logic [63:0] lo_reg;

    logic [31:0] mul_a;
    logic [31:0] mul_b;
    logic [63:0] mul_full;
    logic [21:0] div_f;
    logic [64:0] sub_full;
    logic [7:0]  decim_next;
    logic [22:0] rise_sum;
    logic        rise_hit;
    logic [63:0] steep_sum;
    logic [31:0] rise_diff;
    logic        steep_hit;
    logic [31:0] fall_amt;
    logic [31:0] height;
    logic        fall_hit;
    logic [1:0]  done_state;

    // shared multiplier operand select
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        unique case (state_reg)
            ST_KEEP: begin
                mul_a = 32'(filter_value_reg);
                mul_b = FiltKeep;
            end
            ST_CUR: begin
                mul_a = 32'(in_reg.adc_sample);
                mul_b = AdcScale;
            end
            ST_DIV: begin
                mul_a = 32'(num_reg);
                mul_b = FiltRecip;
            end
            ST_INT: begin
                mul_a = 32'(div_f);
                mul_b = dt_reg;
            end
            ST_DEC: begin
                mul_a = 32'(decay_reg);
                mul_b = dt_reg;
            end
            ST_STLO: begin
                mul_a = 32'(steep_min_reg);
                mul_b = span_reg[31:0];
            end
            ST_STHI: begin
                mul_a = 32'(steep_min_reg);
                mul_b = span_reg[63:32];
            end
            ST_FALLM: begin
                mul_a = fall_amt;
                mul_b = 32'(ratio_reg);
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_full   = mul_a * mul_b;
    assign div_f      = prod_reg[FiltShift +: 22];
    assign sub_full   = {1'b0, integ_reg} - {1'b0, prod_reg};
    assign decim_next = decim_reg + 8'd1;
    assign rise_sum   = {1'b0, edge_level_reg} + {1'b0, rise_thr_reg};
    assign rise_hit   = {1'b0, f_reg} >= rise_sum;
    assign steep_sum  = lo_reg + {prod_reg[31:0], 32'd0};
    assign rise_diff  = 32'(f_reg) - 32'(edge_level_reg);
    assign steep_hit  = {32'd0, rise_diff} <= steep_sum;
    assign fall_amt   = 32'(edge_peak_reg) - 32'(f_reg);
    assign height     = 32'(edge_peak_reg) - 32'(edge_level_reg);
    assign fall_hit   = (f_reg < old_reg) && (prod_reg[31:0] > height);
    assign done_state = (in_reg.op == OpClear) ? DetNone : latched_state_reg;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            decay_reg     <= '0;
            limit_reg     <= '1;
            rise_thr_reg  <= '1;
            steep_min_reg <= '0;
            ratio_reg     <= 8'd2;
        end else if (cfg_we) begin
            unique case (cfg_index)
                CfgIntegralDecay:     decay_reg     <= cfg_wdata[21:0];
                CfgIntegralLimit:     limit_reg     <= cfg_wdata[47:0];
                CfgEdgeRiseThreshold: rise_thr_reg  <= cfg_wdata[21:0];
                CfgMinSteepness:      steep_min_reg <= cfg_wdata[15:0];
                CfgFallingRatio:      ratio_reg     <= cfg_wdata[7:0];
                default: begin
                end
            endcase
        end
    end

    // sequencer and datapath
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg         <= ST_IDLE;
            m_valid_reg       <= 1'b0;
            filter_value_reg  <= '0;
            last_time_reg     <= '0;
            integ_reg         <= '0;
            decim_reg         <= '0;
            prev_dec_reg      <= '0;
            edge_level_reg    <= '0;
            edge_time_reg     <= '0;
            edge_peak_reg     <= '0;
            latched_state_reg <= DetNone;
            latched_time_reg  <= '0;
        end else begin
            prod_reg <= mul_full;
            if (m_ready && state_reg != ST_DONE) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (s_valid) begin
                        in_reg    <= s_data;
                        state_reg <= (s_data.op == OpSample) ? ST_KEEP : ST_DONE;
                    end
                end
                ST_KEEP: begin
                    dt_reg    <= 32'(in_reg.sample_time - last_time_reg);
                    state_reg <= ST_CUR;
                end
                ST_CUR: begin
                    num_reg   <= prod_reg[30:0];
                    state_reg <= ST_SUM;
                end
                ST_SUM: begin
                    num_reg   <= num_reg + 31'(prod_reg[21:0]);
                    state_reg <= ST_DIV;
                end
                ST_DIV: begin
                    state_reg <= ST_INT;
                end
                ST_INT: begin
                    f_reg            <= div_f;
                    filter_value_reg <= div_f;
                    last_time_reg    <= in_reg.sample_time;
                    state_reg        <= ST_DEC;
                end
                ST_DEC: begin
                    integ_reg <= integ_reg + prod_reg;
                    state_reg <= ST_SUB;
                end
                ST_SUB: begin
                    integ_reg <= sub_full[64] ? '0 : sub_full[63:0];
                    state_reg <= ST_LIM;
                end
                ST_LIM: begin
                    if (integ_reg > 64'(limit_reg)) begin
                        integ_reg         <= '0;
                        latched_state_reg <= DetOvercurrent;
                        latched_time_reg  <= in_reg.sample_time;
                    end
                    if (decim_next == DecimCount) begin
                        decim_reg <= '0;
                        state_reg <= ST_RISE;
                    end else begin
                        decim_reg <= decim_next;
                        state_reg <= ST_DONE;
                    end
                end
                ST_RISE: begin
                    prev_dec_reg <= f_reg;
                    old_reg      <= prev_dec_reg;
                    span_reg     <= in_reg.sample_time - edge_time_reg;
                    if (rise_hit) begin
                        latched_state_reg <= DetRisingEdge;
                        latched_time_reg  <= edge_time_reg;
                        edge_level_reg    <= f_reg;
                        edge_time_reg     <= in_reg.sample_time;
                        edge_peak_reg     <= f_reg;
                        state_reg         <= ST_DONE;
                    end else begin
                        state_reg <= ST_STLO;
                    end
                end
                ST_STLO: begin
                    state_reg <= ST_STHI;
                end
                ST_STHI: begin
                    lo_reg    <= prod_reg;
                    state_reg <= ST_STCMP;
                end
                ST_STCMP: begin
                    if (steep_hit) begin
                        edge_level_reg <= f_reg;
                        edge_time_reg  <= in_reg.sample_time;
                        edge_peak_reg  <= f_reg;
                    end
                    state_reg <= ST_FALLM;
                end
                ST_FALLM: begin
                    state_reg <= ST_FALLC;
                end
                ST_FALLC: begin
                    if (fall_hit) begin
                        edge_level_reg <= f_reg;
                        edge_time_reg  <= in_reg.sample_time;
                        edge_peak_reg  <= f_reg;
                    end else if (f_reg > edge_peak_reg) begin
                        edge_peak_reg <= f_reg;
                    end
                    state_reg <= ST_DONE;
                end
                ST_DONE: begin
                    if (!m_valid_reg || m_ready) begin
                        out_reg.detect_state     <= done_state;
                        out_reg.event_time       <= (done_state != DetNone) ?
                                                    latched_time_reg : '0;
                        out_reg.filtered_current <= filter_value_reg;
                        m_valid_reg              <= 1'b1;
                        if (in_reg.op == OpReadClear || in_reg.op == OpClear) begin
                            latched_state_reg <= DetNone;
                        end
                        state_reg <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = m_valid_reg;
    assign m_data  = out_reg;

endmodule

`default_nettype wire

// ----- design/mecd_checker.sv -----
`default_nettype none

`include "motor_endstop_current_detector_unit_defines.svh"

module mecd_checker
    import mecd_pkg::*;
(
    input wire logic      aclk,
    input wire logic      aresetn,
    input wire logic      s_valid,
    input wire logic      s_ready,
    input wire logic      m_valid,
    input wire logic      m_ready,
    input wire out_word_t m_data
);

    logic s_take;
    logic m_stall;
    logic m_empty_state;

    assign s_take        = s_valid && s_ready;
    assign m_stall       = m_valid && !m_ready;
    assign m_empty_state = m_valid && (m_data.detect_state == DetNone);

    // one word in work at a time
    `MECD_ASSERT_NEXT(a_one_in_work, s_take, !s_ready, "ready after accept")

    `MECD_ASSERT_NOW(a_no_event_time, m_empty_state, m_data.event_time == '0, "event time set")

    `MECD_ASSERT_NOW(a_filter_range, m_valid, m_data.filtered_current <= FiltMax, "current range")

    `MECD_ASSERT_NEXT(a_result_held, m_stall, m_valid && $stable(m_data), "stalled result changed")

endmodule

bind motor_endstop_current_detector_unit mecd_checker u_mecd_checker (.*);

`default_nettype wire

// ----- verif/motor_endstop_current_detector_unit_test.sv -----
`default_nettype none

module motor_endstop_current_detector_unit_test;
    import mecd_pkg::*;

    localparam logic [1:0] OpIdle = 2'd3;
    localparam int Decimation = 20;
    localparam int CycleLimit = 400000;
    localparam int SettleCycles = 20;

    class endstop_scoreboard;
        logic [21:0] decay_rate;
        logic [47:0] integral_cap;
        logic [21:0] rise_thresh;
        logic [15:0] steep_floor;
        logic [7:0]  fall_ratio;

        logic [21:0] filt;
        logic [63:0] prev_stamp;
        logic [63:0] charge;
        logic [7:0]  decim;
        logic [21:0] last_decimated;
        logic [21:0] edge_level;
        logic [63:0] edge_stamp;
        logic [21:0] edge_top;
        logic [1:0]  latch;
        logic [63:0] latch_stamp;

        out_word_t expected_words[$];
        int mismatches;

        function new();
            decay_rate = '0;
            integral_cap = '1;
            rise_thresh = '1;
            steep_floor = '0;
            fall_ratio = 8'd2;
            filt = '0;
            prev_stamp = '0;
            charge = '0;
            decim = '0;
            last_decimated = '0;
            edge_level = '0;
            edge_stamp = '0;
            edge_top = '0;
            latch = DetNone;
            latch_stamp = '0;
            mismatches = 0;
        endfunction

        function void set_reg(logic [CfgIndexWidth-1:0] idx, logic [CfgDataWidth-1:0] value);
            case (idx)
                CfgIntegralDecay: decay_rate = value[21:0];
                CfgIntegralLimit: integral_cap = value[47:0];
                CfgEdgeRiseThreshold: rise_thresh = value[21:0];
                CfgMinSteepness: steep_floor = value[15:0];
                CfgFallingRatio: fall_ratio = value[7:0];
                default: ;
            endcase
        endfunction

        function void restart_edge(logic [21:0] lvl, logic [63:0] stamp);
            edge_level = lvl;
            edge_stamp = stamp;
            edge_top = lvl;
        endfunction

        function void integrate_sample(logic [11:0] adc, logic [63:0] stamp);
            logic [31:0] cur;
            logic [63:0] acc;
            logic [21:0] f;
            logic [31:0] gap;
            logic [63:0] dt;
            logic [63:0] drain;
            logic [21:0] old;
            logic [63:0] reach;
            logic [31:0] rise32;
            logic [63:0] span64;
            logic [63:0] steep_prod;
            logic [31:0] fall32;
            logic [31:0] height32;
            logic [31:0] prod32;

            cur = adc * 32'd806;
            acc = filt * 64'd178 + cur;
            f = 22'(acc / 64'd179);
            gap = 32'(stamp - prev_stamp);
            dt = {32'b0, gap};
            filt = f;
            prev_stamp = stamp;

            charge = charge + f * dt;
            drain = decay_rate * dt;
            if (charge < drain) charge = '0;
            else charge = charge - drain;
            if (charge > {16'b0, integral_cap}) begin
                charge = '0;
                latch = DetOvercurrent;
                latch_stamp = stamp;
            end

            decim = decim + 8'd1;
            if (decim != 8'(Decimation)) return;
            decim = '0;

            old = last_decimated;
            last_decimated = f;

            reach = {42'b0, edge_level} + {42'b0, rise_thresh};
            if ({42'b0, f} >= reach) begin
                latch = DetRisingEdge;
                latch_stamp = edge_stamp;
                restart_edge(f, stamp);
                return;
            end

            rise32 = 32'(f) - 32'(edge_level);
            span64 = stamp - edge_stamp;
            steep_prod = steep_floor * span64;
            if ({32'b0, rise32} <= steep_prod) restart_edge(f, stamp);

            if (f < old) begin
                fall32 = 32'(edge_top) - 32'(f);
                height32 = 32'(edge_top) - 32'(edge_level);
                prod32 = fall32 * fall_ratio;
                if (prod32 > height32) restart_edge(f, stamp);
            end

            if (f > edge_top) edge_top = f;
        endfunction

        function void note_word(in_word_t w);
            out_word_t exp_word;
            logic [1:0] st;

            if (w.op == OpSample) integrate_sample(w.adc_sample, w.sample_time);
            st = latch;
            if (w.op == OpClear) begin
                latch = DetNone;
                st = DetNone;
            end else if (w.op == OpReadClear) begin
                latch = DetNone;
            end
            exp_word.detect_state = st;
            exp_word.event_time = (st != DetNone) ? latch_stamp : 64'd0;
            exp_word.filtered_current = filt;
            expected_words.push_back(exp_word);
        endfunction

        function void check_word(out_word_t got);
            out_word_t want;

            if (expected_words.size() == 0) begin
                $display("%0t: unexpected result word %h", $time, got);
                mismatches++;
                return;
            end
            want = expected_words.pop_front();
            if (got.detect_state !== want.detect_state) begin
                $display("%0t: detect_state expected %0d got %0d", $time,
                         want.detect_state, got.detect_state);
                mismatches++;
            end
            if (got.event_time !== want.event_time) begin
                $display("%0t: event_time expected %h got %h", $time,
                         want.event_time, got.event_time);
                mismatches++;
            end
            if (got.filtered_current !== want.filtered_current) begin
                $display("%0t: filtered_current expected %0d got %0d", $time,
                         want.filtered_current, got.filtered_current);
                mismatches++;
            end
        endfunction

        function int pending();
            return expected_words.size();
        endfunction
    endclass

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    in_word_t s_data = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    out_word_t m_data;
    logic cfg_we = 1'b0;
    logic [CfgIndexWidth-1:0] cfg_index = '0;
    logic [CfgDataWidth-1:0] cfg_wdata = '0;

    endstop_scoreboard sb = new();
    bit calm = 1'b0;
    int unsigned cycle_count = 0;
    logic [63:0] now_us = '0;
    int level = 0;
    int hold_left = 0;

    motor_endstop_current_detector_unit #(
        .DECIMATION(Decimation)
    ) dut (
        .aclk(aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_data(s_data),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_data(m_data),
        .cfg_we(cfg_we),
        .cfg_index(cfg_index),
        .cfg_wdata(cfg_wdata)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CycleLimit) begin
            $display("motor_endstop_current_detector_unit_test: FAIL");
            $finish;
        end
    end

    always @(posedge aclk) begin
        if (!aresetn) m_ready <= 1'b0;
        else m_ready <= calm || ($urandom_range(0, 99) >= 6);
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) sb.check_word(m_data);
    end

    function automatic in_word_t word_of(logic [1:0] op, logic [11:0] adc, logic [63:0] stamp);
        in_word_t w;
        w.op = op;
        w.adc_sample = adc;
        w.sample_time = stamp;
        return w;
    endfunction

    task automatic send_word(input in_word_t w);
        if (!calm) begin
            while ($urandom_range(0, 99) < 6) begin
                s_valid <= 1'b0;
                @(posedge aclk);
            end
        end
        s_valid <= 1'b1;
        s_data <= w;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        sb.note_word(w);
    endtask

    task automatic wait_idle();
        s_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge aclk);
    endtask

    task automatic put_reg(input logic [CfgIndexWidth-1:0] idx,
                           input logic [CfgDataWidth-1:0] value);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        sb.set_reg(idx, value);
        @(posedge aclk);
    endtask

    task automatic load_settings(input logic [21:0] decay, input logic [47:0] cap,
                                 input logic [21:0] thresh, input logic [15:0] steep,
                                 input logic [7:0] ratio);
        @(posedge aclk);
        put_reg(CfgIntegralDecay, 48'(decay));
        put_reg(CfgIntegralLimit, cap);
        put_reg(CfgEdgeRiseThreshold, 48'(thresh));
        put_reg(CfgMinSteepness, 48'(steep));
        put_reg(CfgFallingRatio, 48'(ratio));
        cfg_we <= 1'b0;
    endtask

    task automatic run_random(input int count);
        in_word_t w;
        int roll;
        int adc_val;

        for (int i = 0; i < count; i++) begin
            roll = $urandom_range(0, 99);
            w.adc_sample = 12'($urandom);
            w.sample_time = {$urandom, $urandom};
            if (roll < 5) begin
                w.op = OpReadClear;
            end else if (roll < 7) begin
                w.op = OpClear;
            end else if (roll < 9) begin
                w.op = OpIdle;
            end else begin
                w.op = OpSample;
                // current held at one level for a while, then a step
                if (hold_left == 0) begin
                    level = int'($urandom_range(0, 4095));
                    hold_left = int'($urandom_range(10, 80));
                end
                hold_left--;
                if ($urandom_range(0, 19) != 0) begin
                    adc_val = level + int'($urandom_range(0, 60)) - 30;
                    if (adc_val < 0) adc_val = 0;
                    if (adc_val > 4095) adc_val = 4095;
                    w.adc_sample = 12'(adc_val);
                end
                roll = $urandom_range(0, 199);
                if (roll == 0) now_us = {$urandom, $urandom};
                else if (roll < 4) now_us = now_us + {$urandom_range(0, 3), $urandom};
                else if (roll >= 7) now_us = now_us + 64'($urandom_range(20, 120));
                w.sample_time = now_us;
            end
            send_word(w);
        end
    endtask

    initial begin
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // register defaults
        send_word(word_of(OpSample, 12'h000, 64'd0));
        send_word(word_of(OpSample, 12'hFFF, 64'd1));
        send_word(word_of(OpSample, 12'hFFF, 64'hFFFF_FFFF_FFFF_FFFF));
        send_word(word_of(OpReadClear, 12'h000, 64'd0));
        send_word(word_of(OpReadClear, 12'hFFF, 64'hFFFF_FFFF_FFFF_FFFF));
        send_word(word_of(OpSample, 12'hFFF, 64'd5));
        send_word(word_of(OpSample, 12'h800, 64'd5));
        send_word(word_of(OpSample, 12'hFFF, 64'h0000_0001_0000_0010));
        send_word(word_of(OpSample, 12'hFFF, 64'h0000_0001_FFFF_FFF0));
        send_word(word_of(OpSample, 12'h7FF, 64'h0000_0001_FFFF_FFF8));
        send_word(word_of(OpClear, 12'hFFF, 64'hFFFF_FFFF_FFFF_FFFF));
        send_word(word_of(OpSample, 12'h000, 64'h0000_0002_0000_0000));
        send_word(word_of(OpIdle, 12'hABC, 64'h5555_AAAA_5555_AAAA));
        send_word(word_of(OpIdle, 12'h543, 64'hAAAA_5555_AAAA_5555));
        send_word(word_of(OpSample, 12'h001, 64'h8000_0000_0000_0000));
        send_word(word_of(OpReadClear, 12'h000, 64'd0));
        now_us = 64'h8000_0000_0000_0000;
        wait_idle();

        load_settings(22'd0, 48'h0002_0000_0000, 22'd400000, 16'd0, 8'd2);
        run_random(150);
        wait_idle();

        // extremes, no idling on either side
        calm = 1'b1;
        load_settings(22'h3F_FFFF, 48'd0, 22'd0, 16'hFFFF, 8'hFF);
        run_random(100);
        wait_idle();
        calm = 1'b0;

        load_settings(22'd0, 48'hFFFF_FFFF_FFFF, 22'h3F_FFFF, 16'd0, 8'd1);
        run_random(100);
        wait_idle();

        for (int p = 0; p < 3; p++) begin
            load_settings(22'($urandom_range(0, 1800000)),
                          48'({$urandom_range(0, 15), $urandom}),
                          22'($urandom_range(0, 1500000)),
                          16'($urandom_range(0, 400)),
                          8'($urandom_range(1, 255)));
            run_random(130);
            wait_idle();
        end

        repeat (SettleCycles) @(posedge aclk);
        if (sb.mismatches == 0 && sb.pending() == 0) begin
            $display("motor_endstop_current_detector_unit_test: PASS");
        end else begin
            $display("motor_endstop_current_detector_unit_test: FAIL");
        end
        $finish;
    end

endmodule

`default_nettype wire

// ----- files.f -----
+incdir+design
design/mecd_pkg.sv
design/motor_endstop_current_detector_unit.sv
design/mecd_checker.sv
verif/motor_endstop_current_detector_unit_test.sv
